@@ rtl/dits_pkg.sv @@
// Shared types and constants of the discrete inverse transform sampler.
package dits_pkg;

  localparam int unsigned IndexW = 5;
  localparam int unsigned ValueW = 32;
  localparam int unsigned ProbW  = 33;
  localparam int unsigned UniW   = 32;
  localparam int unsigned CountW = 6;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_DRAW  = 1'b1
  } op_e;

  typedef struct packed {
    op_e                      op;
    logic [IndexW-1:0]        index;
    logic signed [ValueW-1:0] value;
    logic [ProbW-1:0]         prob;
    logic [UniW-1:0]          uniform;
  } cmd_t;

endpackage

@@ rtl/dits_if.sv @@
// Channel interfaces of the sampler: item input, result output, count config.
interface dits_in_if;
  import dits_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     opcode;
  logic [IndexW-1:0]        entry_index;
  logic signed [ValueW-1:0] entry_value;
  logic [ProbW-1:0]         entry_prob;
  logic [UniW-1:0]          uniform;

  modport source (
    output valid, opcode, entry_index, entry_value, entry_prob, uniform,
    input  ready
  );
  modport sink (
    input  valid, opcode, entry_index, entry_value, entry_prob, uniform,
    output ready
  );
endinterface

interface dits_out_if;
  import dits_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [ValueW-1:0] sample_value;
  logic [IndexW-1:0]        sample_index;
  logic                     past_total;

  modport source (
    output valid, sample_value, sample_index, past_total,
    input  ready
  );
  modport sink (
    input  valid, sample_value, sample_index, past_total,
    output ready
  );
endinterface

interface dits_cfg_if;
  import dits_pkg::*;

  logic              valid;
  logic              ready;
  logic [CountW-1:0] entry_count;

  modport source (
    output valid, entry_count,
    input  ready
  );
  modport sink (
    input  valid, entry_count,
    output ready
  );
endinterface

@@ rtl/dits_front.sv @@
// Front end: accepts items, drops out-of-table writes, queues commands for the back end.
module dits_front #(
  parameter int unsigned MAX_ENTRIES = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  dits_in_if.sink          in_i,
  output logic             cmd_valid_o,
  input  logic             cmd_ready_i,
  output dits_pkg::cmd_t   cmd_o
);
  import dits_pkg::*;

  localparam int unsigned QDepth = 2;
  localparam int unsigned PtrW   = $clog2(QDepth);
  localparam int unsigned CntW   = $clog2(QDepth + 1);

  cmd_t            queue_q [QDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  cmd_t cmd_in;
  logic keep;
  logic push;
  logic pop;

  always_comb begin
    cmd_in.op      = op_e'(in_i.opcode);
    cmd_in.index   = in_i.entry_index;
    cmd_in.value   = in_i.entry_value;
    cmd_in.prob    = in_i.entry_prob;
    cmd_in.uniform = in_i.uniform;
  end

  // writes beyond the table are taken and dropped
  assign keep = (cmd_in.op == OP_DRAW) ||
                (32'(in_i.entry_index) < 32'(MAX_ENTRIES));

  assign in_i.ready  = (cnt_q != CntW'(QDepth));
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = queue_q[rd_ptr_q];

  assign push = in_i.valid && in_i.ready && keep;
  assign pop  = cmd_valid_o && cmd_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (32'(wr_ptr_q) == QDepth - 1) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (32'(rd_ptr_q) == QDepth - 1) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

@@ rtl/dits_back.sv @@
// Back end: table memory, cumulative walk over entries, result register.
module dits_back #(
  parameter int unsigned MAX_ENTRIES = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cmd_valid_i,
  output logic                           cmd_ready_o,
  input  dits_pkg::cmd_t                 cmd_i,
  input  logic [$clog2(MAX_ENTRIES)-1:0] last_i,
  dits_out_if.source                     out_o
);
  import dits_pkg::*;

  localparam int unsigned IdxW = $clog2(MAX_ENTRIES);
  localparam int unsigned SumW = ProbW + IdxW;

  typedef enum logic {
    ST_IDLE,
    ST_WALK
  } state_e;

  state_e state_q;

  logic [ValueW-1:0] value_mem [MAX_ENTRIES];
  logic [ProbW-1:0]  prob_mem  [MAX_ENTRIES];
  logic [ValueW-1:0] rd_value_q;
  logic [ProbW-1:0]  rd_prob_q;
  logic [IdxW-1:0]   rd_addr;
  logic              rd_en;

  logic [IdxW-1:0]   k_q;
  logic [IdxW-1:0]   last_q;
  logic [SumW-1:0]   sum_q;
  logic [UniW-1:0]   uni_q;

  logic [SumW-1:0]   sum_next;
  logic              hit;
  logic              done;
  logic              stall;
  logic              take;
  logic              wr_en;

  logic                     out_valid_q;
  logic signed [ValueW-1:0] out_value_q;
  logic [IndexW-1:0]        out_index_q;
  logic                     out_past_q;

  assign cmd_ready_o = (state_q == ST_IDLE);
  assign take        = cmd_valid_i && cmd_ready_o;
  assign wr_en       = take && (cmd_i.op == OP_WRITE);

  assign sum_next = sum_q + SumW'(rd_prob_q);
  assign hit      = SumW'(uni_q) < sum_next;
  assign done     = hit || (k_q == last_q);
  assign stall    = (state_q == ST_WALK) && done && out_valid_q && !out_o.ready;

  assign rd_addr = (state_q == ST_IDLE) ? '0 : k_q + 1'b1;
  assign rd_en   = !stall;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      value_mem[IdxW'(cmd_i.index)] <= cmd_i.value;
      prob_mem[IdxW'(cmd_i.index)]  <= cmd_i.prob;
    end
    if (rd_en) begin
      rd_value_q <= value_mem[rd_addr];
      rd_prob_q  <= prob_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      k_q         <= '0;
      sum_q       <= '0;
      last_q      <= '0;
      uni_q       <= '0;
      out_value_q <= '0;
      out_index_q <= '0;
      out_past_q  <= 1'b0;
    end else begin
      if ((state_q == ST_WALK) && done && !stall) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (take && (cmd_i.op == OP_DRAW)) begin
            k_q     <= '0;
            sum_q   <= '0;
            last_q  <= last_i;
            uni_q   <= cmd_i.uniform;
            state_q <= ST_WALK;
          end
        end
        ST_WALK: begin
          if (!done) begin
            k_q   <= k_q + 1'b1;
            sum_q <= sum_next;
          end else if (!stall) begin
            out_value_q <= rd_value_q;
            out_index_q <= IndexW'(k_q);
            out_past_q  <= !hit;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.sample_value = out_value_q;
  assign out_o.sample_index = out_index_q;
  assign out_o.past_total   = out_past_q;

endmodule

@@ rtl/discrete_inverse_transform_sampler.sv @@
// Discrete inverse transform sampler: top level with entry count register.
// Write items (opcode 0) load one table entry of value and probability; draw
// items (opcode 1) return the first active entry whose running probability
// sum exceeds the uniform fraction, or the last active entry with past_total
// set. Items pass a two-deep command queue into the back end, which walks the
// table memory one entry per clock: a draw occupies the back end until the
// walk reaches the chosen entry, and holds there while an earlier result
// still waits to be taken; a write is done as it is accepted. The walk adds
// and compares on the registered memory read. The result sits in an output
// register, so the next item is taken while a result waits. Table entries
// hold no reset value; only written entries may be drawn. The entry count is
// written through the config channel, which is always ready; 0 counts as 1
// and values above MAX_ENTRIES saturate.
module discrete_inverse_transform_sampler #(
  parameter int unsigned MAX_ENTRIES = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  dits_cfg_if.sink    cfg_i,
  dits_in_if.sink     in_i,
  dits_out_if.source  out_o
);
  import dits_pkg::*;

  localparam int unsigned IdxW = $clog2(MAX_ENTRIES);

  logic [IdxW-1:0]   last_q, last_d;
  logic [CountW-1:0] cfg_cnt;

  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  assign cfg_i.ready = 1'b1;
  assign cfg_cnt     = cfg_i.entry_count;

  always_comb begin
    if (cfg_cnt == '0) begin
      last_d = '0;
    end else if (32'(cfg_cnt) > 32'(MAX_ENTRIES)) begin
      last_d = IdxW'(MAX_ENTRIES - 1);
    end else begin
      last_d = IdxW'(cfg_cnt - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= '0;
    end else if (cfg_i.valid && cfg_i.ready) begin
      last_q <= last_d;
    end
  end

  dits_front #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .cmd_valid_o(cmd_valid),
    .cmd_ready_i(cmd_ready),
    .cmd_o      (cmd)
  );

  dits_back #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(cmd_valid),
    .cmd_ready_o(cmd_ready),
    .cmd_i      (cmd),
    .last_i     (last_q),
    .out_o      (out_o)
  );

endmodule
